[src/oli_pkg.sv]
// ----------------------------------------------------------------------------
// oli_pkg
// Shared types and codes for the ordered list block: operation and status
// codes, the transfer payloads of both channels and the cell control group.
// ----------------------------------------------------------------------------
package oli_pkg;

  localparam int unsigned DefaultCapacity = 16;
  localparam int unsigned PosW            = 5;
  localparam int unsigned DataW           = 32;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_GET    = 3'd2,
    OP_LOCATE = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]              operation;
    logic [PosW-1:0]         position;
    logic signed [DataW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [DataW-1:0] read_value;
    logic [PosW-1:0]         found_position;
    logic [PosW-1:0]         count;
    logic                    is_empty;
  } out_item_t;

  typedef struct packed {
    logic ins;
    logic del;
  } cell_ctrl_t;

endpackage

[src/oli_cell.sv]
// ----------------------------------------------------------------------------
// oli_cell
// One list cell: holds one entry, loads the new value or its left neighbor on
// insert, from its right neighbor on delete, and compares its entry for locate.
// ----------------------------------------------------------------------------
module oli_cell #(
  parameter int unsigned Capacity = oli_pkg::DefaultCapacity,
  parameter int unsigned Idx      = 0,
  localparam int unsigned IW      = (Capacity > 1) ? $clog2(Capacity) : 1
) (
  input  logic                            clk_i,
  input  oli_pkg::cell_ctrl_t             ctrl_i,
  input  logic [IW-1:0]                   pidx_i,
  input  logic signed [oli_pkg::DataW-1:0] value_i,
  input  logic signed [oli_pkg::DataW-1:0] left_i,
  input  logic signed [oli_pkg::DataW-1:0] right_i,
  output logic signed [oli_pkg::DataW-1:0] entry_o,
  output logic                            match_o
);
  import oli_pkg::*;

  localparam logic [IW-1:0] IdxL = IW'(Idx);

  logic signed [DataW-1:0] entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (IdxL == pidx_i) begin
        entry_d = value_i;
      end else if (IdxL > pidx_i) begin
        entry_d = left_i;
      end
    end else if (ctrl_i.del) begin
      if (IdxL >= pidx_i) begin
        entry_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign match_o = (entry_q == value_i);

endmodule

[src/ordered_list_insert_delete_top.sv]
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_top
// Fixed-capacity ordered list built as a row of shifting cells.
// Output: the result is registered in the cycle after the input transfer.
// Throughput: one operation per cycle unless stalled; the cell row shifts and
// compares in parallel; the locate priority encoder resolves in that cycle.
// Reset: asynchronous active low, clears the fill count and output valid.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete_top #(
  parameter int unsigned Capacity = oli_pkg::DefaultCapacity
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  oli_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output oli_pkg::out_item_t out_data_o
);
  import oli_pkg::*;

  localparam int unsigned IW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned NW = $clog2(Capacity + 1);
  localparam int unsigned CW = ((NW > PosW) ? NW : PosW) + 1;

  logic [NW-1:0]           count_q, count_d;
  logic                    out_valid_q, out_valid_d;
  out_item_t               out_q, out_d;
  logic                    accept;
  cell_ctrl_t              ctrl;
  logic [IW-1:0]           pidx;
  logic [CW-1:0]           pos_c, cnt_c, found_c;
  logic signed [DataW-1:0] entries [Capacity];
  logic [Capacity-1:0]     match;
  logic                    ins_ok, rd_ok, hit;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign pos_c      = CW'(in_data_i.position);
  assign cnt_c      = CW'(count_q);
  assign pidx       = IW'(pos_c - CW'(1));

  assign ins_ok = (pos_c >= CW'(1)) && (pos_c <= cnt_c + CW'(1));
  assign rd_ok  = (pos_c >= CW'(1)) && (pos_c <= cnt_c);

  assign ctrl.ins = accept && (in_data_i.operation == OP_INSERT) && ins_ok
                    && (cnt_c < CW'(Capacity));
  assign ctrl.del = accept && (in_data_i.operation == OP_DELETE) && rd_ok;

  for (genvar g = 0; g < Capacity; g++) begin : g_cell
    oli_cell #(
      .Capacity(Capacity),
      .Idx     (g)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .pidx_i (pidx),
      .value_i(in_data_i.value),
      .left_i (entries[(g == 0) ? 0 : g - 1]),
      .right_i(entries[(g == Capacity - 1) ? g : g + 1]),
      .entry_o(entries[g]),
      .match_o(match[g])
    );
  end

  always_comb begin
    hit     = 1'b0;
    found_c = '0;
    for (int j = Capacity - 1; j >= 0; j--) begin
      if (match[j] && (CW'(j) < cnt_c)) begin
        hit     = 1'b1;
        found_c = CW'(j + 1);
      end
    end
  end

  always_comb begin
    count_d     = count_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      out_d.status         = ST_OK;
      out_d.read_value     = '0;
      out_d.found_position = '0;
      case (in_data_i.operation)
        OP_INSERT: begin
          if (!ins_ok) begin
            out_d.status = ST_BADPOS;
          end else if (cnt_c >= CW'(Capacity)) begin
            out_d.status = ST_FULL;
          end else begin
            count_d = count_q + NW'(1);
          end
        end
        OP_DELETE, OP_GET: begin
          if (!rd_ok) begin
            out_d.status = ST_BADPOS;
          end else begin
            out_d.read_value = entries[pidx];
            if (in_data_i.operation == OP_DELETE) begin
              count_d = count_q - NW'(1);
            end
          end
        end
        OP_LOCATE: begin
          if (hit) begin
            out_d.found_position = PosW'(found_c);
          end else begin
            out_d.status = ST_NOTFOUND;
          end
        end
        OP_CLEAR: begin
          count_d = '0;
        end
        default: begin
        end
      endcase
      out_d.count    = PosW'(CW'(count_d));
      out_d.is_empty = (count_d == '0);
      out_valid_d    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
